@@ src/pscs_pkg.sv @@
`timescale 1ns / 1ps

package pscs_pkg;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic [1:0] RUN_MAX   = 2'd3;
    localparam logic [1:0] BLANK_MAX = 2'd2;

    typedef enum logic [1:0] {
        DOC_NONE   = 2'd0,
        DOC_SINGLE = 2'd1,
        DOC_DOUBLE = 2'd2
    } doc_mode_t;

    typedef struct packed {
        doc_mode_t  doc_mode;
        logic       single_open;
        logic [1:0] single_run;
        logic       double_open;
        logic [1:0] double_run;
        logic       escape_flag;
        logic       in_comment;
        logic [1:0] blank_run;
        logic [7:0] prev_byte;
        logic       last_out_newline;
    } pscs_state_t;

    typedef struct packed {
        logic [1:0] run;
        logic       open;
        logic       other_open;
        doc_mode_t  doc_mode;
        logic       drop;
    } quote_res_t;

    // One quote character of kind qch; mine is the docstring code of that kind.
    function automatic quote_res_t quote_event(
        input logic [1:0] run,
        input logic       open,
        input logic       other_open,
        input doc_mode_t  doc_mode,
        input logic [7:0] prev_byte,
        input logic [7:0] qch,
        input doc_mode_t  mine,
        input logic       escape_flag
    );
        quote_res_t r;
        r.run        = run;
        r.open       = open;
        r.other_open = other_open;
        r.doc_mode   = doc_mode;
        r.drop       = 1'b0;
        if (doc_mode != DOC_NONE)
        begin
            if (run == RUN_MAX)
                r.run = 2'd2;
            else if (prev_byte == qch)
                r.run = run - 2'd1;
            else
                r.run = RUN_MAX;
            r.doc_mode = (r.run != 2'd0) ? mine : DOC_NONE;
            if (r.doc_mode == DOC_NONE)
                r.drop = 1'b1;
        end
        else
        begin
            if (run == 2'd0 && !(open || other_open))
                r.run = 2'd1;
            else if (prev_byte == qch)
                r.run = run + 2'd1;
            r.doc_mode = (r.run == RUN_MAX) ? mine : DOC_NONE;
            if (r.doc_mode != DOC_NONE)
            begin
                r.open       = 1'b0;
                r.other_open = 1'b0;
                r.drop       = 1'b1;
            end
            else if (!other_open)
            begin
                if (open)
                begin
                    if (!escape_flag)
                    begin
                        r.open = 1'b0;
                        r.drop = 1'b1;
                    end
                end
                else
                begin
                    r.open = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage

@@ src/pscs_step.sv @@
`timescale 1ns / 1ps

module pscs_step (
    input  pscs_pkg::pscs_state_t cur,
    input  logic [7:0]            in_byte,
    output pscs_pkg::pscs_state_t nxt,
    output logic                  emit
);
    import pscs_pkg::*;

    quote_res_t q;
    logic       drop;
    logic       quoted;

    always_comb
    begin
        nxt    = cur;
        drop   = 1'b0;
        emit   = 1'b0;
        quoted = 1'b0;
        q      = '0;
        if (!cur.in_comment && !(cur.single_open || cur.double_open || cur.doc_mode != DOC_NONE)
            && !cur.escape_flag && in_byte == CH_HASH)
        begin
            nxt.in_comment = 1'b1;
            nxt.blank_run  = 2'd0;
            nxt.prev_byte  = in_byte;
        end
        else if (cur.in_comment && in_byte != CH_NEWLINE)
        begin
            nxt.prev_byte = in_byte;
        end
        else
        begin
            case (in_byte) inside
                CH_NEWLINE:
                begin
                    drop           = cur.last_out_newline;
                    nxt.in_comment = 1'b0;
                    nxt.blank_run  = 2'd0;
                end
                CH_DQUOTE:
                begin
                    if (cur.doc_mode != DOC_SINGLE)
                    begin
                        q = quote_event(cur.double_run, cur.double_open, cur.single_open,
                                        cur.doc_mode, cur.prev_byte, CH_DQUOTE, DOC_DOUBLE,
                                        cur.escape_flag);
                        nxt.double_run  = q.run;
                        nxt.double_open = q.open;
                        nxt.single_open = q.other_open;
                        nxt.doc_mode    = q.doc_mode;
                        drop            = q.drop;
                    end
                    nxt.blank_run = 2'd0;
                end
                CH_SQUOTE:
                begin
                    if (cur.doc_mode != DOC_DOUBLE)
                    begin
                        q = quote_event(cur.single_run, cur.single_open, cur.double_open,
                                        cur.doc_mode, cur.prev_byte, CH_SQUOTE, DOC_SINGLE,
                                        cur.escape_flag);
                        nxt.single_run  = q.run;
                        nxt.single_open = q.open;
                        nxt.double_open = q.other_open;
                        nxt.doc_mode    = q.doc_mode;
                        drop            = q.drop;
                    end
                    nxt.blank_run = 2'd0;
                end
                CH_SPACE, CH_TAB:
                begin
                    if (cur.last_out_newline)
                        drop = 1'b1;
                    else if (cur.blank_run < BLANK_MAX)
                        nxt.blank_run = cur.blank_run + 2'd1;
                end
                default:
                begin
                    nxt.blank_run = 2'd0;
                end
            endcase

            if (nxt.doc_mode == DOC_SINGLE)
            begin
                if (nxt.single_run < RUN_MAX && in_byte != CH_SQUOTE)
                    nxt.single_run = RUN_MAX;
                nxt.double_run = 2'd0;
            end
            else if (nxt.doc_mode == DOC_DOUBLE)
            begin
                if (nxt.double_run < RUN_MAX && in_byte != CH_DQUOTE)
                    nxt.double_run = RUN_MAX;
                nxt.single_run = 2'd0;
            end
            else
            begin
                if (in_byte != CH_SQUOTE)
                    nxt.single_run = 2'd0;
                if (in_byte != CH_DQUOTE)
                    nxt.double_run = 2'd0;
            end

            quoted = nxt.single_open || nxt.double_open || nxt.doc_mode != DOC_NONE;
            if (!drop && !quoted && nxt.blank_run < BLANK_MAX)
            begin
                emit                 = 1'b1;
                nxt.last_out_newline = (in_byte == CH_NEWLINE);
            end

            nxt.escape_flag = (in_byte == CH_BACKSLASH) ? !cur.escape_flag : 1'b0;
            nxt.prev_byte   = in_byte;
        end
    end

endmodule

@@ src/python_comment_string_stripper_unit.sv @@
`timescale 1ns / 1ps

// Strips '#' comments, quoted strings and triple quoted docstrings from a
// Python source byte stream, squeezes blank runs to one, and drops leading
// blanks and repeated newlines. One byte per beat in, zero or one byte per
// beat out. Throughput is one byte per cycle while the sink does not stall;
// a byte is taken into the input register, run through the scanner state
// update, and its result, if any, is held in the output register. The input
// side stalls only while the output register holds a beat that the sink is
// stalling.
module python_comment_string_stripper_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte
);
    import pscs_pkg::*;

    logic        in_vld_reg;
    logic        in_vld_next;
    logic [7:0]  in_byte_reg;
    logic        out_vld_reg;
    logic        out_vld_next;
    logic [7:0]  out_byte_reg;
    pscs_state_t state_reg;
    pscs_state_t state_next;
    logic        emit;
    logic        advance;

    pscs_step u_step (
        .cur     (state_reg),
        .in_byte (in_byte_reg),
        .nxt     (state_next),
        .emit    (emit)
    );

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign out_valid = out_vld_reg;
    assign out_byte  = out_byte_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_valid && !in_stall)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (advance)
            out_vld_next = emit;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= in_byte;
        if (advance && emit)
            out_byte_reg <= in_byte_reg;
    end

endmodule

@@ src/pscs_checker.sv @@
`timescale 1ns / 1ps

module pscs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte
);

    // input backs up only behind a stalled output beat
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output beat");

    // a fresh output beat must trace back to an accepted input beat
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("output beat without a source input beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_byte))
        else $error("output byte changed while stalled");

endmodule

bind python_comment_string_stripper_unit pscs_checker u_pscs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte)
);
